// ===== src/grdda_pkg.sv =====
// grdda_pkg: shared types, constants and helpers for the grid ray stepper
// used by every module of the block, depends on nothing
package grdda_pkg;

  localparam int CoordW = 32;
  localparam int SpW = 31;
  localparam int DirW = 16;
  localparam int CordicIters = 15;
  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic signed [DirW-1:0] DirOne = 16'sd16384;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  // one queued request between front and back
  typedef struct packed {
    logic kind;
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] origin_y;
    logic [15:0] angle;
    logic signed [CoordW-1:0] corner_x;
    logic signed [CoordW-1:0] corner_y;
  } req_t;

  typedef struct packed {
    logic signed [CoordW-1:0] hit_x;
    logic signed [CoordW-1:0] hit_y;
    logic signed [CoordW-1:0] cell_x;
    logic signed [CoordW-1:0] cell_y;
    logic [SpW-1:0] len;
    logic vert;
  } res_t;

  function automatic logic [13:0] atan_turn(input logic [3:0] i);
    logic [13:0] r;
    case (i)
      4'd0: r = 14'd8192;
      4'd1: r = 14'd4836;
      4'd2: r = 14'd2555;
      4'd3: r = 14'd1297;
      4'd4: r = 14'd651;
      4'd5: r = 14'd326;
      4'd6: r = 14'd163;
      4'd7: r = 14'd81;
      4'd8: r = 14'd41;
      4'd9: r = 14'd20;
      4'd10: r = 14'd10;
      4'd11: r = 14'd5;
      4'd12: r = 14'd3;
      default: r = 14'd1;
    endcase
    return r;
  endfunction

  function automatic logic signed [CoordW-1:0] sat64(input logic signed [63:0] v);
    logic signed [CoordW-1:0] r;
    if (v > 64'(CoordMax)) r = CoordMax;
    else if (v < 64'(CoordMin)) r = CoordMin;
    else r = v[CoordW-1:0];
    return r;
  endfunction

endpackage

// ===== src/grdda_divider.sv =====
// grdda_divider: unsigned restoring divider, one quotient bit per cycle
// depends on grdda_pkg
module grdda_divider
  import grdda_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] num,
  input  logic [14:0] den,
  output logic        busy,
  output logic [47:0] quo
);
  logic [5:0] cnt;
  logic [47:0] n;
  logic [15:0] rem;
  logic [15:0] trial;

  assign trial = {rem[14:0], n[47]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 6'd48;
      n <= num;
      rem <= '0;
    end else if (busy) begin
      if (!trial[15]) begin
        rem <= trial;
        n <= {n[46:0], 1'b1};
      end else begin
        rem <= {rem[14:0], n[47]};
        n <= {n[46:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end
  assign quo = n;
endmodule

// ===== src/grdda_front.sv =====
// grdda_front: accepts requests and holds them in a two-entry queue
// depends on grdda_pkg
module grdda_front
  import grdda_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic q_valid,
  input  logic q_take,
  output req_t q_req
);
  req_t slot [2];
  logic rd, wr;
  logic [1:0] cnt;
  logic wen;

  assign in_ready = (cnt != 2'd2);
  assign wen = in_valid && in_ready;
  assign q_valid = (cnt != 2'd0);
  assign q_req = slot[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= 1'b0;
      wr <= 1'b0;
      cnt <= '0;
    end else begin
      if (wen) wr <= ~wr;
      if (q_take && q_valid) rd <= ~rd;
      cnt <= cnt + 2'(wen) - 2'(q_take && q_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (wen) slot[wr] <= in_req;
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue overflow");
  a_take_ok: assert property (@(posedge clk) disable iff (rst)
    q_take |-> q_valid) else $error("take from empty queue");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    (wen && !q_take) |=> cnt == $past(cnt) + 2'd1) else $error("count slip");
`endif
endmodule

// ===== src/grdda_back.sv =====
// grdda_back: ray setup sequencer (cordic, divisions) and grid step unit
// depends on grdda_pkg and grdda_divider
module grdda_back
  import grdda_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic [SpW-1:0] spacing,
  input  logic           q_valid,
  output logic           q_take,
  input  req_t           q_req,
  output logic           res_valid,
  input  logic           res_ready,
  output res_t           res
);
  localparam logic [3:0] S_IDLE = 4'd0, S_CORD = 4'd1, S_DIR = 4'd2,
    S_DIV = 4'd3, S_DWAIT = 4'd4, S_MUL = 4'd5, S_STEP = 4'd6;

  logic [3:0] state;
  logic signed [CoordW-1:0] org [2];
  logic signed [DirW-1:0] dir [2];
  logic signed [CoordW-1:0] dlt [2];
  logic signed [CoordW-1:0] side [2];
  logic signed [CoordW-1:0] corner [2];
  logic sgn [2];

  logic signed [33:0] cx, cy;
  logic signed [15:0] cz;
  logic [3:0] it;
  logic [1:0] quad;
  logic zero_rem;
  logic [1:0] dj;   // division job: axis*2 + (0 delta,1 side)
  logic signed [63:0] px, py;
  logic ax;

  logic dstart, dbusy;
  logic [47:0] dnum, dquo;
  logic [14:0] dden;
  logic [14:0] dmag;
  logic signed [63:0] numv;
  logic dneg;

  grdda_divider u_div (
    .clk(clk), .rst(rst), .start(dstart), .num(dnum), .den(dden),
    .busy(dbusy), .quo(dquo)
  );

  logic signed [DirW-1:0] dcur;
  logic signed [CoordW-1:0] ocur, kcur;
  assign dcur = dir[dj[1]];
  assign ocur = org[dj[1]];
  assign kcur = corner[dj[1]];
  assign dmag = dcur[DirW-1] ? 15'(-dcur) : dcur[14:0];
  // numerator magnitude goes into the divider already shifted up by 14
  always_comb begin
    if (!dj[0]) numv = 64'(spacing);
    else if (!dcur[DirW-1]) numv = 64'(kcur) + 64'(spacing) - 64'(ocur);
    else numv = 64'(ocur) - 64'(kcur);
    dneg = numv[63];
    dnum = dneg ? 48'((-numv) <<< 14) : 48'(numv <<< 14);
    dden = dmag;
  end
  logic signed [63:0] qv;
  assign qv = 64'(dquo);

  // cordic rounding and clamp
  function automatic logic signed [DirW-1:0] rnd(input logic signed [33:0] v);
    logic signed [33:0] t;
    logic signed [17:0] r;
    t = v + 34'sd32768;
    r = 18'(t >>> 16);
    if (r > 18'sd16384) r = 18'sd16384;
    if (r < -18'sd16384) r = -18'sd16384;
    return r[DirW-1:0];
  endfunction

  logic signed [DirW-1:0] cc, ss;
  assign cc = zero_rem ? DirOne : rnd(cx);
  assign ss = zero_rem ? '0 : rnd(cy);

  logic [SpW-1:0] lenv;
  logic signed [CoordW-1:0] t;
  assign t = side[ax];
  // the most negative distance has no 31-bit magnitude, it clamps
  assign lenv = (t == CoordMin) ? {SpW{1'b1}} :
    t[CoordW-1] ? SpW'(-t) : t[SpW-1:0];

  assign q_take = (state == S_IDLE) && q_valid &&
    (q_req.kind == KIND_START || !res_valid || res_ready);
  assign dstart = (state == S_DIV);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      for (int a = 0; a < 2; a++) begin
        org[a] <= '0; dir[a] <= '0; dlt[a] <= '0;
        side[a] <= '0; corner[a] <= '0; sgn[a] <= 1'b0;
      end
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_take) begin
            if (q_req.kind == KIND_START) begin
              org[0] <= q_req.origin_x; org[1] <= q_req.origin_y;
              corner[0] <= q_req.corner_x; corner[1] <= q_req.corner_y;
              quad <= q_req.angle[15:14];
              zero_rem <= (q_req.angle[13:0] == 14'd0);
              cx <= CordicGain; cy <= '0;
              cz <= 16'(q_req.angle[13:0]);
              it <= '0;
              state <= S_CORD;
            end else begin
              ax <= ((side[0][CoordW-1] ? -64'(side[0]) : 64'(side[0])) <
                     (side[1][CoordW-1] ? -64'(side[1]) : 64'(side[1]))) ? 1'b0 : 1'b1;
              state <= S_MUL;
            end
          end
        end
        S_CORD: begin
          if (!cz[15]) begin
            cx <= cx - (cy >>> it); cy <= cy + (cx >>> it);
            cz <= cz - 16'(atan_turn(it));
          end else begin
            cx <= cx + (cy >>> it); cy <= cy - (cx >>> it);
            cz <= cz + 16'(atan_turn(it));
          end
          it <= it + 4'd1;
          if (it == 4'(CordicIters - 1)) state <= S_DIR;
        end
        S_DIR: begin
          unique case (quad)
            2'd0: begin dir[0] <= cc; dir[1] <= ss; end
            2'd1: begin dir[0] <= -ss; dir[1] <= cc; end
            2'd2: begin dir[0] <= -cc; dir[1] <= -ss; end
            default: begin dir[0] <= ss; dir[1] <= -cc; end
          endcase
          dj <= 2'd0;
          state <= S_DIV;
        end
        S_DIV: begin
          sgn[dj[1]] <= !dcur[DirW-1] && (dcur != '0);
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (!dbusy) begin
            if (!dj[0]) dlt[dj[1]] <= (dmag == '0) ? CoordMax : sat64(qv);
            else side[dj[1]] <= (dmag == '0) ? CoordMax : sat64(dneg ? -qv : qv);
            dj <= dj + 2'd1;
            state <= (dj == 2'd3) ? S_IDLE : S_DIV;
          end
        end
        S_MUL: begin
          px <= 64'(t) * 64'(dir[0]);
          py <= 64'(t) * 64'(dir[1]);
          state <= S_STEP;
        end
        default: begin
          res.hit_x <= sat64(64'(org[0]) + ((px + 64'sd8192) >>> 14));
          res.hit_y <= sat64(64'(org[1]) + ((py + 64'sd8192) >>> 14));
          res.len <= lenv;
          res.vert <= ~ax;
          side[ax] <= sat64(64'(t) + 64'(dlt[ax]));
          if (!ax) begin
            res.cell_x <= sgn[0] ? corner[0] + CoordW'(spacing) : corner[0] - CoordW'(spacing);
            res.cell_y <= corner[1];
            corner[0] <= sgn[0] ? corner[0] + CoordW'(spacing) : corner[0] - CoordW'(spacing);
          end else begin
            res.cell_x <= corner[0];
            res.cell_y <= sgn[1] ? corner[1] + CoordW'(spacing) : corner[1] - CoordW'(spacing);
            corner[1] <= sgn[1] ? corner[1] + CoordW'(spacing) : corner[1] - CoordW'(spacing);
          end
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_step_out: assert property (@(posedge clk) disable iff (rst)
    state == S_STEP |=> res_valid) else $error("step gave no result");
  a_dir_mag: assert property (@(posedge clk) disable iff (rst)
    dir[0] <= DirOne && dir[0] >= -DirOne) else $error("direction out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready && state != S_STEP) |=> $stable(res))
    else $error("result changed while stalled");
`endif
endmodule

// ===== src/grid_ray_dda_stepper.sv =====
// grid_ray_dda_stepper: top level, queue front and setup/step back end
// depends on grdda_pkg, grdda_front, grdda_back
//
// channel  dir  handshake                 payload
// s_axis   in   s_axis_tvalid/tready      tdata, tuser = kind
// m_axis   out  m_axis_tvalid/tready      tdata
// cfg      in   cfg_valid/cfg_ready       cfg_data = mesh_spacing
//
// a step request passes through the queue, then through the back end
// (take, multiply, result register) before its result is valid
// a start request holds the back end through take, 15 cordic iterations, direction,
// then 4 divisions through the shared bit-serial divider
// synchronous reset clears state; spacing resets to 64.0
// the two-entry queue keeps taking requests while the back end is busy or stalled, until it is full
module grid_ray_dda_stepper
  import grdda_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // origin_x, origin_y, angle, corner_x, corner_y from bit 0 up
  input  logic [143:0] s_axis_tdata,
  // kind
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit_x, hit_y, cell_x_out, cell_y_out, ray_length, hit_vertical from bit 0 up
  output logic [159:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [30:0]  cfg_data
);
  logic [SpW-1:0] spacing;
  req_t in_req, q_req;
  res_t res;
  logic q_valid, q_take;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) spacing <= 31'd4194304;
    else if (cfg_valid) spacing <= cfg_data;
  end

  assign in_req = '{kind: s_axis_tuser, origin_x: s_axis_tdata[31:0],
    origin_y: s_axis_tdata[63:32], angle: s_axis_tdata[79:64],
    corner_x: s_axis_tdata[111:80], corner_y: s_axis_tdata[143:112]};

  grdda_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_req(in_req), .q_valid(q_valid), .q_take(q_take), .q_req(q_req)
  );

  grdda_back u_back (
    .clk(clk), .rst(rst), .spacing(spacing), .q_valid(q_valid),
    .q_take(q_take), .q_req(q_req), .res_valid(m_axis_tvalid),
    .res_ready(m_axis_tready), .res(res)
  );

  assign m_axis_tdata = {res.vert, res.len, res.cell_y, res.cell_x,
    res.hit_y, res.hit_x};
endmodule
